FILE: rtl/core/dbla_pkg.sv
// ----------------------------------------------------------------------------
// dbla_pkg
// Shared types, widths and event codes of the debounced level alarm.
// ----------------------------------------------------------------------------
package dbla_pkg;

  localparam int unsigned SENSOR_W         = 3;
  localparam int unsigned POWER_W          = 32;
  localparam int unsigned CNT_W            = 16;
  localparam int unsigned EVT_W            = 2;
  localparam int unsigned SENSOR_COUNT_DEF = 8;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned S_TDATA_W        = 104;
  localparam int unsigned M_TDATA_W        = 16;
  localparam int unsigned APB_ADDR_W       = 3;
  localparam int unsigned APB_DATA_W       = 32;

  localparam logic [CNT_W-1:0] STOP_LIMIT_RST  = 16'd10;
  localparam logic [CNT_W-1:0] START_LIMIT_RST = 16'd10;

  // register select bit of paddr
  localparam logic REG_STOP_LIMIT  = 1'b0;
  localparam logic REG_START_LIMIT = 1'b1;

  localparam logic [EVT_W-1:0] EVT_NONE  = 2'd0;
  localparam logic [EVT_W-1:0] EVT_SET   = 2'd1;
  localparam logic [EVT_W-1:0] EVT_CLEAR = 2'd2;

  // classified item handed from front to back
  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic                sensor_valid;
    logic                hit_pre;
    logic                hit_stop;
    logic                round_end;
  } item_t;

  // result transaction, sensor_out in the lowest bits
  typedef struct packed {
    logic [EVT_W-1:0]    stop_event;
    logic [EVT_W-1:0]    pre_event;
    logic                stop_status;
    logic                pre_stop_status;
    logic [SENSOR_W-1:0] sensor_out;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] pre_hit;
    logic [CNT_W-1:0] pre_miss;
    logic [CNT_W-1:0] stop_miss;
    logic             pre_flag;
    logic             stop_flag;
  } sensor_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] stop_limit;
    logic [CNT_W-1:0] start_limit;
  } cfg_t;

endpackage

FILE: rtl/core/dbla_front.sv
// ----------------------------------------------------------------------------
// dbla_front
// Takes input transactions and classifies them into hit/miss items.
// ----------------------------------------------------------------------------
module dbla_front #(
  parameter int unsigned SENSOR_COUNT = dbla_pkg::SENSOR_COUNT_DEF
) (
  input  logic [dbla_pkg::SENSOR_W-1:0] sensor_i,
  input  logic [dbla_pkg::POWER_W-1:0]  power_i,
  input  logic [dbla_pkg::POWER_W-1:0]  threshold_pre_i,
  input  logic [dbla_pkg::POWER_W-1:0]  threshold_stop_i,
  input  logic                          threshold_ready_i,
  input  logic                          round_end_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output dbla_pkg::item_t               item_o
);

  assign ready_o = ~queue_full_i;
  assign push_o  = valid_i & ~queue_full_i;

  always_comb begin
    item_o.sensor       = sensor_i;
    item_o.sensor_valid = (int'(sensor_i) < int'(SENSOR_COUNT));
    item_o.hit_pre      = threshold_ready_i & (power_i > threshold_pre_i);
    item_o.hit_stop     = threshold_ready_i & (power_i > threshold_stop_i);
    item_o.round_end    = round_end_i;
  end

endmodule

FILE: rtl/core/dbla_queue.sv
// ----------------------------------------------------------------------------
// dbla_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module dbla_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dbla_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output dbla_pkg::item_t item_o
);

  localparam int unsigned DEPTH = dbla_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dbla_pkg::item_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/core/dbla_back.sv
// ----------------------------------------------------------------------------
// dbla_back
// Per-sensor debounce state, round OR, edge events and output register.
// ----------------------------------------------------------------------------
module dbla_back #(
  parameter int unsigned SENSOR_COUNT = dbla_pkg::SENSOR_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dbla_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  dbla_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dbla_pkg::result_t out_o
);

  // the sensor field is 3 bits wide, so at most 8 sensors can be addressed
  localparam int unsigned DEPTH = (SENSOR_COUNT < 8) ? SENSOR_COUNT : 8;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dbla_pkg::sensor_state_t state_q [DEPTH];
  dbla_pkg::sensor_state_t cur, nxt;
  logic [IDX_W-1:0]        idx;
  logic                    any_pre_q, any_pre_d;
  logic                    any_stop_q, any_stop_d;
  logic                    pre_sent_q, pre_sent_d;
  logic                    stop_sent_q, stop_sent_d;
  logic                    out_valid_q, out_valid_d;
  dbla_pkg::result_t       out_q, res;
  logic                    any_pre, any_stop;

  assign pop_o       = item_valid_i & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign idx         = item_i.sensor[IDX_W-1:0];

  always_comb begin
    cur = state_q[idx];
    nxt = cur;

    if (item_i.hit_pre) begin
      if (cur.pre_hit >= cfg_i.stop_limit) begin
        nxt.pre_flag = 1'b1;
      end else begin
        nxt.pre_hit = cur.pre_hit + dbla_pkg::CNT_W'(1);
      end
      nxt.pre_miss = '0;
    end else begin
      if (cur.pre_miss >= cfg_i.start_limit) begin
        nxt.pre_flag = 1'b0;
      end else begin
        nxt.pre_miss = cur.pre_miss + dbla_pkg::CNT_W'(1);
      end
      nxt.pre_hit = '0;
    end

    if (item_i.hit_stop) begin
      nxt.stop_flag = 1'b1;
      nxt.stop_miss = '0;
    end else if (cur.stop_miss >= cfg_i.start_limit) begin
      nxt.stop_flag = 1'b0;
    end else begin
      nxt.stop_miss = cur.stop_miss + dbla_pkg::CNT_W'(1);
    end

    res.sensor_out      = item_i.sensor;
    res.pre_stop_status = item_i.sensor_valid & nxt.pre_flag;
    res.stop_status     = item_i.sensor_valid & nxt.stop_flag;

    any_pre  = any_pre_q | res.pre_stop_status;
    any_stop = any_stop_q | res.stop_status;

    res.pre_event  = dbla_pkg::EVT_NONE;
    res.stop_event = dbla_pkg::EVT_NONE;
    pre_sent_d     = pre_sent_q;
    stop_sent_d    = stop_sent_q;
    any_pre_d      = any_pre;
    any_stop_d     = any_stop;

    if (item_i.round_end) begin
      any_pre_d  = 1'b0;
      any_stop_d = 1'b0;
      if (any_pre != pre_sent_q) begin
        res.pre_event = any_pre ? dbla_pkg::EVT_SET : dbla_pkg::EVT_CLEAR;
        pre_sent_d    = any_pre;
      end
      if (any_stop != stop_sent_q) begin
        res.stop_event = any_stop ? dbla_pkg::EVT_SET : dbla_pkg::EVT_CLEAR;
        stop_sent_d    = any_stop;
      end
    end

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(DEPTH); i++) begin
        state_q[i] <= '0;
      end
      any_pre_q   <= 1'b0;
      any_stop_q  <= 1'b0;
      pre_sent_q  <= 1'b0;
      stop_sent_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        if (item_i.sensor_valid) begin
          state_q[idx] <= nxt;
        end
        any_pre_q   <= any_pre_d;
        any_stop_q  <= any_stop_d;
        pre_sent_q  <= pre_sent_d;
        stop_sent_q <= stop_sent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

endmodule

FILE: rtl/core/debounced_level_alarm_with_edges_top.sv
// ----------------------------------------------------------------------------
// debounced_level_alarm_with_edges_top
// Debounced two-level threshold alarm with round-end edge events.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transaction per sensor reading, carrying the sensor
//   index, power and both thresholds in tdata, threshold_ready in tuser and
//   round_end in tlast. Each accepted transaction gives exactly one result
//   transaction on the output stream, in order.
//   Path: the classified item enters a 2-entry queue when its input is
//   accepted, and the per-sensor state update is then applied into the
//   output register, which drives the result.
//   Throughput: one transaction per cycle while the output is not stalled;
//   the back end updates the per-sensor state at the same edge that loads
//   the output register, so consecutive items of the same sensor need no stall.
//   Stall: when m_axis_tready_i is low the result holds in the output
//   register; the queue absorbs up to two more items, then s_axis_tready_o
//   drops.
//   Reset: all counters, statuses, round ORs and sent bits clear at once;
//   both debounce limits return to 10. No clearing pass is needed.
//   APB: stop_debounce_limit at 0x0, start_debounce_limit at 0x4; write
//   only while the block is idle.
// ----------------------------------------------------------------------------
module debounced_level_alarm_with_edges_top #(
  parameter int unsigned SENSOR_COUNT = dbla_pkg::SENSOR_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // [2:0] sensor, [34:3] power, [66:35] threshold_pre, [98:67] threshold_stop
  input  logic [dbla_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] threshold_ready
  input  logic                            s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [2:0] sensor_out, [3] pre_stop_status, [4] stop_status,
  // [6:5] pre_event, [8:7] stop_event
  output logic [dbla_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dbla_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dbla_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dbla_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  dbla_pkg::cfg_t    cfg_q, cfg_d;
  dbla_pkg::item_t   front_item, queue_item;
  dbla_pkg::result_t result;
  logic              push, pop, queue_full, queue_valid;
  logic              cfg_wr;

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        dbla_pkg::REG_STOP_LIMIT:  cfg_d.stop_limit  = pwdata[dbla_pkg::CNT_W-1:0];
        dbla_pkg::REG_START_LIMIT: cfg_d.start_limit = pwdata[dbla_pkg::CNT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
    unique case (paddr[2])
      dbla_pkg::REG_STOP_LIMIT:
        prdata = {{(dbla_pkg::APB_DATA_W - dbla_pkg::CNT_W){1'b0}}, cfg_q.stop_limit};
      dbla_pkg::REG_START_LIMIT:
        prdata = {{(dbla_pkg::APB_DATA_W - dbla_pkg::CNT_W){1'b0}}, cfg_q.start_limit};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_limit  <= dbla_pkg::STOP_LIMIT_RST;
      cfg_q.start_limit <= dbla_pkg::START_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dbla_front #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_front (
    .sensor_i         (s_axis_tdata_i[2:0]),
    .power_i          (s_axis_tdata_i[34:3]),
    .threshold_pre_i  (s_axis_tdata_i[66:35]),
    .threshold_stop_i (s_axis_tdata_i[98:67]),
    .threshold_ready_i(s_axis_tuser_i),
    .round_end_i      (s_axis_tlast_i),
    .valid_i          (s_axis_tvalid_i),
    .ready_o          (s_axis_tready_o),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .item_o           (front_item)
  );

  dbla_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(queue_valid),
    .item_o (queue_item)
  );

  dbla_back #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(queue_valid),
    .item_i      (queue_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result)
  );

  assign m_axis_tdata_o = {{(dbla_pkg::M_TDATA_W - $bits(dbla_pkg::result_t)){1'b0}}, result};

endmodule

FILE: test/debounced_level_alarm_with_edges_top_test.sv
// ----------------------------------------------------------------------------
// debounced_level_alarm_with_edges_top_test
// Self-checking bench: drives sensor readings on the input stream and
// predicts each result transaction, covering per-sensor debounce, status
// and round-end edge events. It covers field extremes, zero and maximum
// debounce limits, and limits lowered below a running counter. Random rounds
// then run under several limit settings, with random gaps and stalls on both
// streams, except in the last setting.
// ----------------------------------------------------------------------------
module debounced_level_alarm_with_edges_top_test;

  localparam int unsigned SENSOR_COUNT   = dbla_pkg::SENSOR_COUNT_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned PHASE_ITEMS    = 170;
  localparam logic [dbla_pkg::APB_ADDR_W-1:0] ADDR_STOP_LIMIT  = 3'd0;
  localparam logic [dbla_pkg::APB_ADDR_W-1:0] ADDR_START_LIMIT = 3'd4;
  localparam logic [dbla_pkg::POWER_W-1:0]    POWER_MAX        = '1;
  localparam logic [dbla_pkg::CNT_W-1:0]      LIMIT_MAX        = '1;

  typedef struct {
    logic [dbla_pkg::SENSOR_W-1:0] sensor;
    logic [dbla_pkg::POWER_W-1:0]  power;
    logic [dbla_pkg::POWER_W-1:0]  th_pre;
    logic [dbla_pkg::POWER_W-1:0]  th_stop;
    logic                          ready;
    logic                          last;
  } reading_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic [dbla_pkg::S_TDATA_W-1:0]  s_axis_tdata_i;
  logic                            s_axis_tuser_i;
  logic                            s_axis_tlast_i;
  logic                            s_axis_tvalid_i;
  logic                            s_axis_tready_o;
  logic [dbla_pkg::M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [dbla_pkg::APB_ADDR_W-1:0] paddr;
  logic [dbla_pkg::APB_DATA_W-1:0] pwdata;
  logic [dbla_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // predictor state
  logic [dbla_pkg::CNT_W-1:0] stop_limit;
  logic [dbla_pkg::CNT_W-1:0] start_limit;
  logic [dbla_pkg::CNT_W-1:0] pre_hits    [SENSOR_COUNT];
  logic [dbla_pkg::CNT_W-1:0] pre_misses  [SENSOR_COUNT];
  logic [dbla_pkg::CNT_W-1:0] stop_misses [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] pre_status;
  logic [SENSOR_COUNT-1:0] stop_status;
  logic any_pre;
  logic any_stop;
  logic pre_reported;
  logic stop_reported;

  dbla_pkg::result_t alarm_results_q[$];
  logic [SENSOR_COUNT-1:0] level_hi;
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned sink_stall_left;
  bit src_idle_en;
  bit sink_idle_en;

  debounced_level_alarm_with_edges_top #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatch_count < 10) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
    mismatch_count++;
  endtask

  function automatic logic [dbla_pkg::EVT_W-1:0] alarm_edge(input logic any,
                                                            input logic sent);
    if (any && !sent) return dbla_pkg::EVT_SET;
    if (!any && sent) return dbla_pkg::EVT_CLEAR;
    return dbla_pkg::EVT_NONE;
  endfunction

  function automatic dbla_pkg::result_t predict_alarm(input reading_t r);
    dbla_pkg::result_t res;
    logic hit_pre;
    logic hit_stop;
    int unsigned i;
    res = '0;
    res.sensor_out = r.sensor;
    if (r.sensor < SENSOR_COUNT) begin
      i = int'(r.sensor);
      hit_pre  = r.ready && (r.power > r.th_pre);
      hit_stop = r.ready && (r.power > r.th_stop);
      if (hit_pre) begin
        if (pre_hits[i] >= stop_limit) pre_status[i] = 1'b1;
        else pre_hits[i]++;
        pre_misses[i] = '0;
      end else begin
        if (pre_misses[i] >= start_limit) pre_status[i] = 1'b0;
        else pre_misses[i]++;
        pre_hits[i] = '0;
      end
      if (hit_stop) begin
        stop_status[i] = 1'b1;
        stop_misses[i] = '0;
      end else if (stop_misses[i] >= start_limit) begin
        stop_status[i] = 1'b0;
      end else begin
        stop_misses[i]++;
      end
      res.pre_stop_status = pre_status[i];
      res.stop_status     = stop_status[i];
      any_pre  |= pre_status[i];
      any_stop |= stop_status[i];
    end
    if (r.last) begin
      res.pre_event  = alarm_edge(any_pre, pre_reported);
      res.stop_event = alarm_edge(any_stop, stop_reported);
      pre_reported  = any_pre;
      stop_reported = any_stop;
      any_pre  = 1'b0;
      any_stop = 1'b0;
    end
    return res;
  endfunction

  function automatic reading_t reading_of(input logic [dbla_pkg::SENSOR_W-1:0] sensor,
                                          input logic [dbla_pkg::POWER_W-1:0] power,
                                          input logic [dbla_pkg::POWER_W-1:0] th_pre,
                                          input logic [dbla_pkg::POWER_W-1:0] th_stop,
                                          input logic ready, input logic last);
    reading_t r;
    r.sensor  = sensor;
    r.power   = power;
    r.th_pre  = th_pre;
    r.th_stop = th_stop;
    r.ready   = ready;
    r.last    = last;
    return r;
  endfunction

  // power is steered by the sensor's current level so debounce runs form
  function automatic reading_t make_reading(input logic [dbla_pkg::SENSOR_W-1:0] sensor,
                                            input logic last);
    reading_t r;
    logic want_pre;
    logic want_stop;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned a;
    longint unsigned b;
    a = 64'($urandom >> $urandom_range(0, 16));
    b = 64'($urandom >> $urandom_range(0, 16));
    r.sensor = sensor;
    r.last   = last;
    r.ready  = ($urandom_range(0, 15) != 0);
    if ($urandom_range(0, 3) != 0 && a > b) begin
      r.th_pre  = 32'(b);
      r.th_stop = 32'(a);
    end else begin
      r.th_pre  = 32'(a);
      r.th_stop = 32'(b);
    end
    want_pre  = level_hi[sensor] ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0);
    want_stop = level_hi[sensor] ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 15) == 0);
    lo = 64'd0;
    hi = 64'(POWER_MAX);
    if (want_pre) lo = 64'(r.th_pre) + 64'd1;
    else hi = 64'(r.th_pre);
    if (want_stop) begin
      if (64'(r.th_stop) + 64'd1 > lo) lo = 64'(r.th_stop) + 64'd1;
    end else if (64'(r.th_stop) < hi) begin
      hi = 64'(r.th_stop);
    end
    if (lo <= hi && $urandom_range(0, 15) != 0) begin
      r.power = 32'(lo + ({$urandom, $urandom} % (hi - lo + 64'd1)));
    end else begin
      r.power = $urandom;
    end
    return r;
  endfunction

  task automatic send_reading(input reading_t r);
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tdata_i  = {5'b0, r.th_stop, r.th_pre, r.power, r.sensor};
    s_axis_tuser_i  = r.ready;
    s_axis_tlast_i  = r.last;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    alarm_results_q.push_back(predict_alarm(r));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (alarm_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write one limit, then read it back
  task automatic program_limit(input logic [dbla_pkg::APB_ADDR_W-1:0] addr,
                               input logic [dbla_pkg::CNT_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {16'b0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_STOP_LIMIT) stop_limit = value;
    else start_limit = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'b0, value}) note_mismatch("limit readback", {16'b0, value}, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_field_extremes();
    send_reading(reading_of(3'd0, POWER_MAX, '0, '0, 1'b1, 1'b0));
    send_reading(reading_of(3'd7, '0, '0, '0, 1'b1, 1'b0));
    send_reading(reading_of(3'd2, POWER_MAX, POWER_MAX, POWER_MAX, 1'b1, 1'b0));
    send_reading(reading_of(3'd3, 32'h8000_0001, 32'h8000_0000, 32'h8000_0001, 1'b1, 1'b0));
    send_reading(reading_of(3'd4, POWER_MAX, '0, '0, 1'b0, 1'b0));
    send_reading(reading_of(3'd5, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554, 1'b1, 1'b1));
    send_reading(reading_of(3'd0, '0, POWER_MAX, POWER_MAX, 1'b1, 1'b1));
  endtask

  task automatic test_zero_limits();
    wait_drained();
    program_limit(ADDR_STOP_LIMIT, '0);
    program_limit(ADDR_START_LIMIT, '0);
    send_reading(reading_of(3'd1, POWER_MAX, '0, '0, 1'b1, 1'b1));
    // same sensor twice in one round
    send_reading(reading_of(3'd1, POWER_MAX, '0, '0, 1'b1, 1'b0));
    send_reading(reading_of(3'd1, '0, '0, '0, 1'b1, 1'b1));
    send_reading(reading_of(3'd6, '0, '0, '0, 1'b1, 1'b1));
  endtask

  task automatic test_lowered_limits();
    wait_drained();
    program_limit(ADDR_STOP_LIMIT, LIMIT_MAX);
    program_limit(ADDR_START_LIMIT, LIMIT_MAX);
    send_reading(reading_of(3'd6, POWER_MAX, '0, '0, 1'b1, 1'b0));
    repeat (3) send_reading(reading_of(3'd6, POWER_MAX, '0, POWER_MAX, 1'b1, 1'b0));
    wait_drained();
    program_limit(ADDR_STOP_LIMIT, 16'd2);
    send_reading(reading_of(3'd6, POWER_MAX, '0, POWER_MAX, 1'b1, 1'b1));
    repeat (3) send_reading(reading_of(3'd6, '0, POWER_MAX, POWER_MAX, 1'b1, 1'b0));
    wait_drained();
    program_limit(ADDR_START_LIMIT, 16'd1);
    send_reading(reading_of(3'd6, '0, POWER_MAX, POWER_MAX, 1'b1, 1'b1));
  endtask

  task automatic run_rounds(input logic [dbla_pkg::CNT_W-1:0] stop_lim,
                            input logic [dbla_pkg::CNT_W-1:0] start_lim, input bit idle);
    int unsigned sent;
    int unsigned order [SENSOR_COUNT];
    int unsigned len;
    int unsigned j;
    int unsigned tmp;
    wait_drained();
    program_limit(ADDR_STOP_LIMIT, stop_lim);
    program_limit(ADDR_START_LIMIT, start_lim);
    src_idle_en  = idle;
    sink_idle_en = idle;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        if ($urandom_range(0, 7) == 0) level_hi[k] = ~level_hi[k];
      end
      if ($urandom_range(0, 4) != 0) begin
        // complete round, shuffled
        for (int k = 0; k < SENSOR_COUNT; k++) order[k] = k;
        for (int k = SENSOR_COUNT - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (int k = 0; k < SENSOR_COUNT; k++) begin
          send_reading(make_reading(dbla_pkg::SENSOR_W'(order[k]), k == SENSOR_COUNT - 1));
        end
        sent += SENSOR_COUNT;
      end else begin
        // partial, repeated or unterminated round
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_reading(make_reading(dbla_pkg::SENSOR_W'($urandom_range(0, SENSOR_COUNT - 1)),
                                    k == len - 1 && $urandom_range(0, 3) != 0));
        end
        sent += len;
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  task automatic test_random_settings();
    run_rounds(16'd1, 16'd1, 1'b1);
    run_rounds(16'd0, 16'd3, 1'b1);
    run_rounds(16'd3, 16'd0, 1'b1);
    run_rounds(16'd2, 16'd2, 1'b1);
    run_rounds(LIMIT_MAX, 16'd1, 1'b1);
    run_rounds(16'd5, LIMIT_MAX, 1'b1);
    run_rounds(dbla_pkg::STOP_LIMIT_RST, dbla_pkg::START_LIMIT_RST, 1'b0);
  endtask

  always @(negedge clk_i) begin
    if (!sink_idle_en) begin
      sink_stall_left = 0;
      m_axis_tready_i <= 1'b1;
    end else if (sink_stall_left > 0) begin
      sink_stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall_left = $urandom_range(0, 14);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    dbla_pkg::result_t got;
    dbla_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = dbla_pkg::result_t'(m_axis_tdata_o[$bits(dbla_pkg::result_t)-1:0]);
      if (alarm_results_q.size() == 0) begin
        note_mismatch("unexpected result", '0, 32'(got));
      end else begin
        want = alarm_results_q.pop_front();
        if (got.sensor_out !== want.sensor_out)
          note_mismatch("sensor_out", 32'(want.sensor_out), 32'(got.sensor_out));
        if (got.pre_stop_status !== want.pre_stop_status)
          note_mismatch("pre_stop_status", 32'(want.pre_stop_status),
                        32'(got.pre_stop_status));
        if (got.stop_status !== want.stop_status)
          note_mismatch("stop_status", 32'(want.stop_status), 32'(got.stop_status));
        if (got.pre_event !== want.pre_event)
          note_mismatch("pre_event", 32'(want.pre_event), 32'(got.pre_event));
        if (got.stop_event !== want.stop_event)
          note_mismatch("stop_event", 32'(want.stop_event), 32'(got.stop_event));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    s_axis_tvalid_i = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    stop_limit      = dbla_pkg::STOP_LIMIT_RST;
    start_limit     = dbla_pkg::START_LIMIT_RST;
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      pre_hits[k]    = '0;
      pre_misses[k]  = '0;
      stop_misses[k] = '0;
    end
    pre_status      = '0;
    stop_status     = '0;
    any_pre         = 1'b0;
    any_stop        = 1'b0;
    pre_reported    = 1'b0;
    stop_reported   = 1'b0;
    level_hi        = '0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    src_idle_en     = 1'b1;
    sink_idle_en    = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_extremes();
    test_zero_limits();
    test_lowered_limits();
    test_random_settings();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
